FILE: sv/crac_pkg.sv
// Shared constants, status codes and types for the contiguous run allocator.
// Used by every module of the block; depends on nothing.
package crac_pkg;

   localparam int NODE_COUNT = 256;
   localparam int SLOT_COUNT = 16;
   localparam int WORD_W     = 16;
   localparam int WORD_CNT   = NODE_COUNT / WORD_W;
   localparam int WORD_AW    = $clog2(WORD_CNT);
   localparam int BIT_AW     = $clog2(WORD_W);
   localparam int NODE_AW    = 8;
   localparam int SLOT_AW    = 4;
   localparam int CNT_W      = 9;
   localparam int RUN_W      = CNT_W + 1;
   localparam int SLOTS_W    = 5;
   localparam int STATUS_W   = 3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_RUN    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SLOT_FREE = 3'd5;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic               found;
      logic [BIT_AW-1:0]  pos;
      logic [NODE_AW-1:0] base;
      logic [CNT_W-1:0]   carry;
   } scan_res_type;

   typedef struct packed {
      logic               set;
      logic               clr;
      logic [SLOT_AW-1:0] addr;
      logic [NODE_AW-1:0] base;
      logic [CNT_W-1:0]   len;
   } slot_cmd_type;

endpackage

FILE: sv/crac_node_map.sv
// Node usage bitmap held as a word-wide memory with a registered read port.
// Rows never written read as free through per-row valid bits; uses crac_pkg.
module crac_node_map (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [crac_pkg::WORD_AW-1:0] rd_addr,
   output logic [crac_pkg::WORD_W-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [crac_pkg::WORD_AW-1:0] wr_addr,
   input  logic [crac_pkg::WORD_W-1:0]  wr_data
);

   logic [crac_pkg::WORD_W-1:0]   mem [crac_pkg::WORD_CNT];
   logic [crac_pkg::WORD_CNT-1:0] row_valid_ff;
   logic [crac_pkg::WORD_W-1:0]   rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/crac_slot_table.sv
// List slot table: used flags in flip-flops, base and length in a memory.
// The memory read is registered; uses crac_pkg for widths and the command type.
module crac_slot_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [crac_pkg::SLOT_AW-1:0]    rd_addr,
   output logic [crac_pkg::NODE_AW-1:0]    rd_base,
   output logic [crac_pkg::CNT_W-1:0]      rd_len,
   input  crac_pkg::slot_cmd_type          cmd,
   output logic [crac_pkg::SLOT_COUNT-1:0] used
);

   logic [crac_pkg::NODE_AW-1:0]    base_mem [crac_pkg::SLOT_COUNT];
   logic [crac_pkg::CNT_W-1:0]      len_mem  [crac_pkg::SLOT_COUNT];
   logic [crac_pkg::NODE_AW-1:0]    rd_base_ff;
   logic [crac_pkg::CNT_W-1:0]      rd_len_ff;
   logic [crac_pkg::SLOT_COUNT-1:0] used_ff;

   always_ff @(posedge clock) begin
      if (cmd.set) begin
         base_mem[cmd.addr] <= cmd.base;
         len_mem[cmd.addr]  <= cmd.len;
      end
      rd_base_ff <= base_mem[rd_addr];
      rd_len_ff  <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.set) begin
         used_ff[cmd.addr] <= 1'b1;
      end else if (cmd.clr) begin
         used_ff[cmd.addr] <= 1'b0;
      end
   end

   assign rd_base = rd_base_ff;
   assign rd_len  = rd_len_ff;
   assign used    = used_ff;

endmodule

FILE: sv/crac_word_scan.sv
// Evaluates one bitmap word of the first-fit search, given the free run
// carried in from earlier words; uses crac_pkg for widths and the result type.
module crac_word_scan (
   input  logic [crac_pkg::WORD_W-1:0]  word,
   input  logic [crac_pkg::WORD_AW-1:0] word_idx,
   input  logic [crac_pkg::CNT_W-1:0]   carry,
   input  logic [crac_pkg::CNT_W-1:0]   count,
   output crac_pkg::scan_res_type       res
);

   logic [crac_pkg::RUN_W-1:0]  run [crac_pkg::WORD_W];
   logic [crac_pkg::WORD_W-1:0] hit;
   logic [crac_pkg::BIT_AW-1:0] pos;
   logic [crac_pkg::RUN_W-1:0]  base_full;

   // For each bit, the length of the free run that ends on it.
   always_comb begin
      for (int j = 0; j < crac_pkg::WORD_W; j++) begin
         automatic logic any_used = 1'b0;
         automatic int   last     = 0;
         for (int i = 0; i < crac_pkg::WORD_W; i++) begin
            if (i <= j && word[i]) begin
               any_used = 1'b1;
               last     = i;
            end
         end
         if (any_used) begin
            run[j] = crac_pkg::RUN_W'(j - last);
         end else begin
            run[j] = crac_pkg::RUN_W'(carry) + crac_pkg::RUN_W'(j + 1);
         end
         hit[j] = run[j] >= crac_pkg::RUN_W'(count);
      end
   end

   always_comb begin
      pos = '0;
      for (int j = crac_pkg::WORD_W - 1; j >= 0; j--) begin
         if (hit[j]) begin
            pos = crac_pkg::BIT_AW'(j);
         end
      end
   end

   assign base_full = crac_pkg::RUN_W'({word_idx, pos}) + crac_pkg::RUN_W'(1)
                      - crac_pkg::RUN_W'(count);

   assign res.found = |hit;
   assign res.pos   = pos;
   assign res.base  = base_full[crac_pkg::NODE_AW-1:0];
   assign res.carry = run[crac_pkg::WORD_W-1][crac_pkg::CNT_W-1:0];

endmodule

FILE: sv/contiguous_run_allocator_core.sv
// Top level of the first-fit contiguous run allocator: request sequencer,
// counters and result register. Instantiates crac_node_map, crac_slot_table
// and crac_word_scan; uses crac_pkg.
//
//   channel   ports                                       handshake
//   request   req_opcode, req_node_count, req_list_id    start, busy
//   result    rsp_status, rsp_slot_id, rsp_base_index,   rsp_valid (one cycle)
//             rsp_run_length
//
// A request is taken when start is high and busy is low; busy then stays high
// until its single result has been shown for one cycle, which the receiver
// cannot hold off. A request refused by its first checks goes from S_CHECK
// straight to S_RESP, and an allocate that finds no contiguous run goes there
// after reading all 16 bitmap words. A successful allocate runs the first-fit
// search (one word per cycle), then reads and writes back each bitmap word the
// run touches; a release first reads its slot from the slot table and then does
// the same.
// Synchronous reset clears the bitmap and the slot flags at once.
module contiguous_run_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [crac_pkg::CNT_W-1:0]          req_node_count,
   input  logic [crac_pkg::SLOT_AW-1:0]        req_list_id,
   output logic                                rsp_valid,
   output logic [crac_pkg::STATUS_W-1:0]       rsp_status,
   output logic [crac_pkg::SLOT_AW-1:0]        rsp_slot_id,
   output logic [crac_pkg::NODE_AW-1:0]        rsp_base_index,
   output logic [crac_pkg::CNT_W-1:0]          rsp_run_length
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_SLOT_RD = 3'd3;
   localparam logic [2:0] S_MARK_RD = 3'd4;
   localparam logic [2:0] S_MARK_WR = 3'd5;
   localparam logic [2:0] S_RESP    = 3'd6;

   logic [2:0]                      state_ff, state_in;
   logic                            op_ff, op_in;
   logic [crac_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [crac_pkg::SLOT_AW-1:0]    slot_ff, slot_in;
   logic [crac_pkg::NODE_AW-1:0]    base_ff, base_in;
   logic [crac_pkg::NODE_AW-1:0]    hi_ff, hi_in;
   logic [crac_pkg::CNT_W-1:0]      len_ff, len_in;
   logic [crac_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [crac_pkg::WORD_AW-1:0]    word_ff, word_in;
   logic [crac_pkg::CNT_W-1:0]      carry_ff, carry_in;
   logic [crac_pkg::CNT_W-1:0]      nodes_ff, nodes_in;
   logic [crac_pkg::SLOTS_W-1:0]    slots_ff, slots_in;

   logic                            nm_rd_en;
   logic [crac_pkg::WORD_AW-1:0]    nm_rd_addr;
   logic [crac_pkg::WORD_W-1:0]     nm_rd_data;
   logic                            nm_wr_en;
   logic [crac_pkg::WORD_W-1:0]     nm_wr_data;
   logic [crac_pkg::WORD_W-1:0]     mark_mask;

   logic [crac_pkg::NODE_AW-1:0]    st_rd_base;
   logic [crac_pkg::CNT_W-1:0]      st_rd_len;
   crac_pkg::slot_cmd_type          st_cmd;
   logic [crac_pkg::SLOT_COUNT-1:0] slot_used;
   logic [crac_pkg::SLOT_AW-1:0]    free_slot;
   logic                            have_free;
   logic                            too_few;

   crac_pkg::scan_res_type          scan_res;

   crac_node_map u_node_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (nm_rd_en),
      .rd_addr (nm_rd_addr),
      .rd_data (nm_rd_data),
      .wr_en   (nm_wr_en),
      .wr_addr (word_ff),
      .wr_data (nm_wr_data)
   );

   crac_slot_table u_slot_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (slot_ff),
      .rd_base (st_rd_base),
      .rd_len  (st_rd_len),
      .cmd     (st_cmd),
      .used    (slot_used)
   );

   crac_word_scan u_word_scan (
      .word     (nm_rd_data),
      .word_idx (word_ff),
      .carry    (carry_ff),
      .count    (count_ff),
      .res      (scan_res)
   );

   always_comb begin
      free_slot = '0;
      for (int i = crac_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_used[i]) begin
            free_slot = crac_pkg::SLOT_AW'(i);
         end
      end
   end

   assign have_free = ~&slot_used;
   assign too_few   = ({1'b0, count_ff} + {1'b0, nodes_ff})
                      > crac_pkg::RUN_W'(crac_pkg::NODE_COUNT);

   always_comb begin
      for (int j = 0; j < crac_pkg::WORD_W; j++) begin
         mark_mask[j] = ({word_ff, crac_pkg::BIT_AW'(j)} >= base_ff)
                        && ({word_ff, crac_pkg::BIT_AW'(j)} <= hi_ff);
      end
   end

   assign nm_wr_data = (op_ff == crac_pkg::OP_ALLOC) ? (nm_rd_data | mark_mask)
                                                      : (nm_rd_data & ~mark_mask);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      base_in    = base_ff;
      hi_in      = hi_ff;
      len_in     = len_ff;
      status_in  = status_ff;
      word_in    = word_ff;
      carry_in   = carry_ff;
      nodes_in   = nodes_ff;
      slots_in   = slots_ff;
      nm_rd_en   = 1'b0;
      nm_rd_addr = word_ff;
      nm_wr_en   = 1'b0;
      st_cmd     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               count_in = req_node_count;
               slot_in  = req_list_id;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = crac_pkg::ST_OK;
            if (op_ff == crac_pkg::OP_ALLOC) begin
               priority if (count_ff == '0) begin
                  status_in = crac_pkg::ST_ZERO;
               end else if (!have_free) begin
                  status_in = crac_pkg::ST_NO_SLOT;
               end else if (too_few) begin
                  status_in = crac_pkg::ST_TOO_FEW;
               end else begin
                  slot_in    = free_slot;
                  word_in    = '0;
                  carry_in   = '0;
                  nm_rd_en   = 1'b1;
                  nm_rd_addr = '0;
               end
            end else if (!slot_used[slot_ff]) begin
               status_in = crac_pkg::ST_SLOT_FREE;
            end
            if (status_in != crac_pkg::ST_OK) begin
               slot_in  = '0;
               base_in  = '0;
               len_in   = '0;
               state_in = S_RESP;
            end else if (op_ff == crac_pkg::OP_ALLOC) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_SLOT_RD;
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               base_in  = scan_res.base;
               hi_in    = {word_ff, scan_res.pos};
               word_in  = scan_res.base[crac_pkg::NODE_AW-1 -: crac_pkg::WORD_AW];
               state_in = S_MARK_RD;
            end else if (word_ff == crac_pkg::WORD_AW'(crac_pkg::WORD_CNT - 1)) begin
               status_in = crac_pkg::ST_NO_RUN;
               slot_in   = '0;
               base_in   = '0;
               len_in    = '0;
               state_in  = S_RESP;
            end else begin
               carry_in   = scan_res.carry;
               word_in    = word_ff + 1'b1;
               nm_rd_en   = 1'b1;
               nm_rd_addr = word_ff + 1'b1;
            end
         end
         S_SLOT_RD: begin
            base_in  = st_rd_base;
            len_in   = st_rd_len;
            hi_in    = st_rd_base + st_rd_len[crac_pkg::NODE_AW-1:0] - 1'b1;
            word_in  = st_rd_base[crac_pkg::NODE_AW-1 -: crac_pkg::WORD_AW];
            state_in = S_MARK_RD;
         end
         S_MARK_RD: begin
            nm_rd_en = 1'b1;
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            nm_wr_en = 1'b1;
            if (word_ff == hi_ff[crac_pkg::NODE_AW-1 -: crac_pkg::WORD_AW]) begin
               st_cmd.addr = slot_ff;
               st_cmd.base = base_ff;
               st_cmd.len  = count_ff;
               if (op_ff == crac_pkg::OP_ALLOC) begin
                  st_cmd.set = 1'b1;
                  len_in     = count_ff;
                  nodes_in   = nodes_ff + count_ff;
                  slots_in   = slots_ff + 1'b1;
               end else begin
                  st_cmd.clr = 1'b1;
                  nodes_in   = (nodes_ff >= len_ff) ? nodes_ff - len_ff : '0;
                  slots_in   = (slots_ff != '0) ? slots_ff - 1'b1 : '0;
               end
               state_in = S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_MARK_RD;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nodes_ff <= '0;
         slots_ff <= '0;
      end else begin
         state_ff <= state_in;
         nodes_ff <= nodes_in;
         slots_ff <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      count_ff  <= count_in;
      slot_ff   <= slot_in;
      base_ff   <= base_in;
      hi_ff     <= hi_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      word_ff   <= word_in;
      carry_ff  <= carry_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_status     = status_ff;
   assign rsp_slot_id    = slot_ff;
   assign rsp_base_index = base_ff;
   assign rsp_run_length = len_ff;

   a_slot_count: assert property (@(posedge clock) disable iff (reset)
      slots_ff == crac_pkg::SLOTS_W'($countones(slot_used)))
      else $error("slot counter disagrees with slot flags");

   a_one_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result shown for more than one cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != crac_pkg::ST_OK |->
         rsp_slot_id == '0 && rsp_base_index == '0 && rsp_run_length == '0)
      else $error("error result carries nonzero fields");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("request accepted without going busy");

endmodule
